// ===== rtl/core/pse_pkg.sv =====
// shared types and constants for the postfix stack evaluator
package pse_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 256;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SHAMT_W     = 5;
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
  localparam int CQ_COUNT_W  = $clog2(CQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_XOR  = 4'd3,
    OP_ROTL = 4'd4,
    OP_ROTR = 4'd5,
    OP_SHL  = 4'd6,
    OP_ASHR = 4'd7,
    OP_AND  = 4'd8,
    OP_OR   = 4'd9,
    OP_NOT  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_BINOP,
    CMD_NOT,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]                   action;
    logic [3:0]                   operator_code;
    logic signed [DATA_WIDTH-1:0] operand_value;
  } token_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;
  } result_t;

  typedef struct packed {
    cmd_kind_t             kind;
    op_t                   op;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/core/pse_front.sv =====
// front end: accepts tokens, classifies them and drops the ones with no effect
module pse_front (
  input  logic            push,
  output logic            full,
  input  pse_pkg::token_t token,
  input  logic            cq_full,
  output logic            cq_push,
  output pse_pkg::cmd_t   cq_cmd
);
  import pse_pkg::*;

  logic keep;

  assign full = cq_full;

  always_comb begin
    keep          = 1'b0;
    cq_cmd.kind   = CMD_PUSH;
    cq_cmd.op     = op_t'(token.operator_code);
    cq_cmd.value  = token.operand_value;
    case (token.action)
      ACT_PUSH: begin
        keep        = 1'b1;
        cq_cmd.kind = CMD_PUSH;
      end
      ACT_APPLY: begin
        // unknown operator codes are no-ops
        if (token.operator_code == OP_NOT) begin
          keep        = 1'b1;
          cq_cmd.kind = CMD_NOT;
        end else if (token.operator_code inside {[OP_ADD:OP_OR]}) begin
          keep        = 1'b1;
          cq_cmd.kind = CMD_BINOP;
        end
      end
      ACT_END: begin
        keep        = 1'b1;
        cq_cmd.kind = CMD_END;
      end
      default: keep = 1'b0;
    endcase
  end

  assign cq_push = push && !cq_full && keep;

endmodule

// ===== rtl/core/pse_cmd_queue.sv =====
// short command queue between the front end and the stack engine
module pse_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pse_pkg::cmd_t wr_cmd,
  output logic          q_full,
  output logic          rd_valid,
  input  logic          rd_en,
  output pse_pkg::cmd_t rd_cmd
);
  import pse_pkg::*;

  cmd_t                  slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr;
  logic [CQ_PTR_W-1:0]   rd_ptr;
  logic [CQ_COUNT_W-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign q_full   = (fill == CQ_COUNT_W'(CQ_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      if (do_wr && !do_rd) fill <= fill + CQ_COUNT_W'(1);
      else if (do_rd && !do_wr) fill <= fill - CQ_COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

endmodule

// ===== rtl/core/pse_back.sv =====
// stack engine: top two entries in registers, the rest in memory, result buffer
module pse_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  pse_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output pse_pkg::result_t result
);
  import pse_pkg::*;

  // stack storage: tos = entry count-1, nos = count-2, third = count-3
  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] tos;
  logic [DATA_WIDTH-1:0] nos;
  logic [DATA_WIDTH-1:0] third;
  logic [COUNT_W-1:0]    count;
  status_t               err;

  // two-entry result buffer
  result_t     obuf [2];
  logic        owr_ptr;
  logic        ord_ptr;
  logic [1:0]  ofill;

  logic                  fire;
  logic                  ok;
  logic                  do_push;
  logic                  do_binop;
  logic                  do_not;
  logic                  is_end;
  logic                  out_wr;
  logic                  out_rd;
  logic [COUNT_W-1:0]    wr_idx;
  logic [COUNT_W-1:0]    rd_idx;
  logic [DATA_WIDTH-1:0] alu;
  logic [SHAMT_W-1:0]    shamt;
  logic [2*DATA_WIDTH-1:0] rot_l;
  logic [2*DATA_WIDTH-1:0] rot_r;
  result_t               end_res;

  assign is_end  = (cmd.kind == CMD_END);
  assign fire    = cmd_valid && (!is_end || ofill != 2'd2);
  assign cmd_pop = fire;
  assign ok      = (err == ST_OK);

  assign do_push  = fire && ok && cmd.kind == CMD_PUSH &&
                    count != COUNT_W'(STACK_DEPTH);
  assign do_binop = fire && ok && cmd.kind == CMD_BINOP && count >= COUNT_W'(2);
  assign do_not   = fire && ok && cmd.kind == CMD_NOT && count != '0;

  assign wr_idx = count - COUNT_W'(2);
  assign rd_idx = count - COUNT_W'(4);

  // a = nos, b = tos
  assign shamt = tos[SHAMT_W-1:0];
  assign rot_l = {nos, nos} << shamt;
  assign rot_r = {nos, nos} >> shamt;

  always_comb begin
    case (cmd.op)
      OP_ADD:  alu = nos + tos;
      OP_SUB:  alu = nos - tos;
      OP_MUL:  alu = nos * tos;
      OP_XOR:  alu = nos ^ tos;
      OP_ROTL: alu = rot_l[2*DATA_WIDTH-1:DATA_WIDTH];
      OP_ROTR: alu = rot_r[DATA_WIDTH-1:0];
      OP_SHL:  alu = nos << shamt;
      OP_ASHR: alu = $unsigned($signed(nos) >>> shamt);
      OP_AND:  alu = nos & tos;
      default: alu = nos | tos;
    endcase
  end

  always_comb begin
    end_res.result_value = '0;
    end_res.status       = ST_OK;
    if (!ok) begin
      end_res.status = err;
    end else if (count == '0) begin
      end_res.status = ST_EMPTY;
    end else begin
      end_res.result_value = tos;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else if (fire) begin
      case (cmd.kind)
        CMD_PUSH: begin
          if (ok) begin
            if (count == COUNT_W'(STACK_DEPTH)) err <= ST_FULL;
            else count <= count + COUNT_W'(1);
          end
        end
        CMD_BINOP: begin
          if (ok) begin
            if (count < COUNT_W'(2)) err <= ST_MISSING;
            else count <= count - COUNT_W'(1);
          end
        end
        CMD_NOT: begin
          if (ok && count == '0) err <= ST_MISSING;
        end
        CMD_END: begin
          count <= '0;
          err   <= ST_OK;
        end
        default: count <= count;
      endcase
    end
  end

  // stack data path
  always_ff @(posedge clk) begin
    if (do_push) begin
      tos   <= cmd.value;
      nos   <= tos;
      third <= nos;
      if (count >= COUNT_W'(2)) mem[wr_idx[ADDR_W-1:0]] <= nos;
    end else if (do_binop) begin
      tos   <= alu;
      nos   <= third;
      third <= mem[rd_idx[ADDR_W-1:0]];
    end else if (do_not) begin
      tos <= ~tos;
    end
  end

  // result buffer
  assign out_wr = fire && is_end;
  assign out_rd = pop && !empty;
  assign empty  = (ofill == 2'd0);
  assign result = obuf[ord_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ofill   <= 2'd0;
    end else begin
      if (out_wr) owr_ptr <= ~owr_ptr;
      if (out_rd) ord_ptr <= ~ord_ptr;
      if (out_wr && !out_rd) ofill <= ofill + 2'd1;
      else if (out_rd && !out_wr) ofill <= ofill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) obuf[owr_ptr] <= end_res;
  end

endmodule

// ===== rtl/core/postfix_stack_evaluator.sv =====
// top level of the postfix stack evaluator
//
// Tokens come in on a queue-style port: a token beat is taken at a clock edge
// where push is high and full is low. Push tokens stack an operand, apply
// tokens run an operator on the top entries, end tokens produce one result.
// Results leave through a queue-style port: while empty is low the oldest
// result sits on the result port and is taken at an edge with pop high.
// Throughput is one token per cycle in steady state. The front end decodes a
// token in the cycle it is taken and writes it to a four-entry command queue;
// the stack engine executes one command per cycle, with the top two entries
// in registers and the third prefetched from the stack memory, so that a
// binary operator needs a single read of that memory's one read port.
// An end token's result is written to the result buffer when the engine executes its command.
// When the result side stalls, end commands wait in the engine until the
// two-entry result buffer has room; the command queue then fills and full
// goes high. Other tokens keep executing as long as no end token is blocked.
// Synchronous reset empties both queues and clears the stack count and the
// error status; the stack memory is not cleared and needs no clearing pass.
module postfix_stack_evaluator (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pse_pkg::token_t  token,
  output logic             empty,
  input  logic             pop,
  output pse_pkg::result_t result
);
  import pse_pkg::*;

  logic cq_full;
  logic cq_push;
  cmd_t cq_wr_cmd;
  logic cq_valid;
  logic cq_pop;
  cmd_t cq_rd_cmd;

  pse_front u_front (
    .push    (push),
    .full    (full),
    .token   (token),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_cmd  (cq_wr_cmd)
  );

  pse_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cq_push),
    .wr_cmd   (cq_wr_cmd),
    .q_full   (cq_full),
    .rd_valid (cq_valid),
    .rd_en    (cq_pop),
    .rd_cmd   (cq_rd_cmd)
  );

  pse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cq_valid),
    .cmd       (cq_rd_cmd),
    .cmd_pop   (cq_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== bench/postfix_stack_evaluator_tb.sv =====
// testbench for the postfix stack evaluator: token streams checked against a stack model
`timescale 1ns / 100ps

module postfix_stack_evaluator_tb;
  import pse_pkg::*;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] OP_CODE_MAX     = 4'd15;
  localparam int unsigned TOTAL_TOKENS   = 1025;
  // a receiver hold may last a while and may repeat, plus a short sender gap
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_HOLD
  } drain_mode_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  token_t  token = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  postfix_stack_evaluator dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .token(token),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  token_t  pending_tokens[$];
  result_t expected_results[$];

  // model state
  logic [DATA_WIDTH-1:0] eval_stack [STACK_DEPTH];
  int unsigned           eval_depth = 0;
  status_t               eval_error = ST_OK;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int unsigned drain_left = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_token(logic [1:0] act, logic [3:0] code,
                                      logic [DATA_WIDTH-1:0] value);
    token_t t;
    t.action        = act;
    t.operator_code = code;
    t.operand_value = value;
    pending_tokens.push_back(t);
  endfunction

  function automatic void queue_push(logic [DATA_WIDTH-1:0] value);
    queue_token(ACT_PUSH, 4'($urandom_range(0, OP_CODE_MAX)), value);
  endfunction

  function automatic void queue_op(logic [3:0] code);
    queue_token(ACT_APPLY, code, pick_word());
  endfunction

  function automatic void queue_end();
    queue_token(ACT_END, 4'($urandom_range(0, OP_CODE_MAX)), pick_word());
  endfunction

  function automatic logic [3:0] pick_binary_op();
    return 4'($urandom_range(OP_ADD, OP_OR));
  endfunction

  // evaluate one accepted token, queue the result an end token produces
  task automatic evaluate_token(input token_t t);
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] r;
    logic [4:0]            amt;
    result_t               res;
    case (t.action)
      ACT_PUSH: if (eval_error == ST_OK) begin
        if (eval_depth == STACK_DEPTH) begin
          eval_error = ST_FULL;
        end else begin
          eval_stack[eval_depth] = t.operand_value;
          eval_depth++;
        end
      end
      ACT_APPLY: if (eval_error == ST_OK) begin
        if (t.operator_code == OP_NOT) begin
          if (eval_depth == 0) eval_error = ST_MISSING;
          else eval_stack[eval_depth-1] = ~eval_stack[eval_depth-1];
        end else if (t.operator_code <= OP_OR) begin
          if (eval_depth < 2) begin
            eval_error = ST_MISSING;
          end else begin
            b   = eval_stack[eval_depth-1];
            a   = eval_stack[eval_depth-2];
            amt = b[4:0];
            case (t.operator_code)
              OP_ADD:  r = a + b;
              OP_SUB:  r = a - b;
              OP_MUL:  r = a * b;
              OP_XOR:  r = a ^ b;
              OP_ROTL: r = (amt == 0) ? a : (a << amt) | (a >> (DATA_WIDTH - amt));
              OP_ROTR: r = (amt == 0) ? a : (a >> amt) | (a << (DATA_WIDTH - amt));
              OP_SHL:  r = a << amt;
              OP_ASHR: r = $signed(a) >>> amt;
              OP_AND:  r = a & b;
              default: r = a | b;
            endcase
            eval_depth--;
            eval_stack[eval_depth-1] = r;
          end
        end
        // unused operator codes leave everything alone
      end
      ACT_END: begin
        res.result_value = '0;
        if (eval_error != ST_OK) begin
          res.status = eval_error;
        end else if (eval_depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status       = ST_OK;
          res.result_value = eval_stack[eval_depth-1];
        end
        expected_results.push_back(res);
        eval_depth = 0;
        eval_error = ST_OK;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : token_drive
    logic send;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        evaluate_token(token);
        void'(pending_tokens.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      send = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pending_tokens.size() > 0) send = 1'b1;
      push <= send;
      if (send) token <= pending_tokens[0];
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: value %h status %0d",
                     result.result_value, result.status);
        end else begin
          want = expected_results.pop_front();
          if (result.result_value !== want.result_value || result.status !== want.status) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                       want.result_value, want.status, result.result_value, result.status);
          end
        end
      end
      if (drain_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(DRAIN_FREE, DRAIN_HOLD));
        drain_left = $urandom_range(1, 40);
      end else begin
        drain_left--;
      end
      case (drain_mode)
        DRAIN_FREE:   pop <= 1'b1;
        DRAIN_RANDOM: pop <= 1'($urandom_range(0, 1));
        default:      pop <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL postfix_stack_evaluator");
      $finish;
    end
  end

  initial begin : run_control
    int unsigned depth;
    int unsigned steps;
    int unsigned kind;
    bit          deep_done;
    bit          full_done;
    deep_done = 1'b0;
    full_done = 1'b0;

    // operator on an empty stack, then an end with nothing stacked
    queue_op(OP_NOT);
    queue_end();
    queue_end();
    // one chained expression through every operator
    queue_push(32'h7FFF_FFFF);
    queue_push(32'h0000_0001);
    queue_op(OP_ADD);
    queue_push(32'h0000_0001);
    queue_op(OP_SUB);
    queue_push(32'hFFFF_FFFF);
    queue_op(OP_MUL);
    queue_push(32'hF0F0_F0F0);
    queue_op(OP_XOR);
    queue_push(32'd36);
    queue_op(OP_ROTL);
    queue_push(32'hFFFF_FFE1);
    queue_op(OP_ROTR);
    queue_push(32'd3);
    queue_op(OP_SHL);
    queue_push(32'h8000_001F);
    queue_op(OP_ASHR);
    queue_push(32'h5A5A_5A5A);
    queue_op(OP_AND);
    queue_push(32'h8000_0000);
    queue_op(OP_OR);
    queue_op(OP_NOT);
    queue_op(OP_FIRST_UNUSED);
    queue_end();

    while (pending_tokens.size() < TOTAL_TOKENS) begin
      if (!deep_done && pending_tokens.size() > 300) begin
        // fill to the last entry, then fold it back through memory
        deep_done = 1'b1;
        repeat (STACK_DEPTH) queue_push(pick_word());
        repeat (24) begin
          if ($urandom_range(0, 4) == 0) queue_op(OP_NOT);
          else queue_op(pick_binary_op());
        end
        queue_end();
      end else if (!full_done && pending_tokens.size() > 650) begin
        full_done = 1'b1;
        repeat (STACK_DEPTH + 2) queue_push(pick_word());
        queue_op(OP_ADD);
        queue_end();
      end else begin
        kind  = $urandom_range(0, 9);
        steps = $urandom_range(1, 14);
        depth = 0;
        if (kind == 0) begin
          // noise, unused actions and codes included
          repeat (steps)
            queue_token(2'($urandom_range(ACT_PUSH, ACT_UNUSED)),
                        4'($urandom_range(0, OP_CODE_MAX)), pick_word());
        end else begin
          if (kind == 1) begin
            // too few operands for the first operator
            depth = $urandom_range(0, 1);
            repeat (depth) queue_push(pick_word());
            if (depth == 0 && $urandom_range(0, 1) == 0) queue_op(OP_NOT);
            else queue_op(pick_binary_op());
          end
          for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 19) == 0) begin
              if ($urandom_range(0, 1) == 0)
                queue_token(ACT_UNUSED, 4'($urandom_range(0, OP_CODE_MAX)), pick_word());
              else
                queue_op(4'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX)));
            end else if (depth < 2 || (depth < 10 && $urandom_range(0, 1) == 0)) begin
              queue_push(pick_word());
              depth++;
            end else if ($urandom_range(0, 5) == 0) begin
              queue_op(OP_NOT);
            end else begin
              queue_op(pick_binary_op());
              depth--;
            end
          end
        end
        queue_end();
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_tokens.size() != 0 || expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("PASS postfix_stack_evaluator");
    else $display("FAIL postfix_stack_evaluator");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pse_pkg.sv
rtl/core/pse_front.sv
rtl/core/pse_cmd_queue.sv
rtl/core/pse_back.sv
rtl/core/postfix_stack_evaluator.sv
bench/postfix_stack_evaluator_tb.sv
